@@ rtl/u8bmp_pkg.sv @@
package u8bmp_pkg;

   localparam logic [15:0] BadCode   = 16'hFFFD;
   localparam logic [7:0]  DelByte   = 8'h7F;
   localparam logic [7:0]  Lead2Mask = 8'b11100000;
   localparam logic [7:0]  Lead2Val  = 8'b11000000;
   localparam logic [7:0]  Lead3Mask = 8'b11110000;
   localparam logic [7:0]  Lead3Val  = 8'b11100000;
   localparam logic [7:0]  Lead4Mask = 8'b11111000;
   localparam logic [7:0]  Lead4Val  = 8'b11110000;
   localparam logic [7:0]  ContMask  = 8'b11000000;
   localparam logic [7:0]  ContVal   = 8'b10000000;

   localparam int WinBytes = 4;
   localparam int CntW     = 3;

   typedef logic [CntW-1:0] cnt_type;

   function automatic logic is_cont(input logic [7:0] b);
      return (b & ContMask) == ContVal;
   endfunction

   function automatic cnt_type seq_len(input logic [7:0] b);
      cnt_type n;
      n = '0;
      if ((b & Lead2Mask) == Lead2Val) begin
         n = cnt_type'(2);
      end else if ((b & Lead3Mask) == Lead3Val) begin
         n = cnt_type'(3);
      end else if ((b & Lead4Mask) == Lead4Val) begin
         n = cnt_type'(4);
      end
      return n;
   endfunction

endpackage

@@ rtl/utf8_to_bmp_codepoint_decoder_top.sv @@
// Streaming UTF-8 decoder: takes one text byte per transaction and gives
// 16-bit code points, one per result transaction. A byte sits in a four-byte
// window (up to three waiting bytes of an unfinished sequence plus the new
// one); each cycle the head of the window is decoded and either gives one
// result or, for an incomplete but so far valid sequence, waits for more
// bytes. A byte that ends a sequence or stands alone is taken every cycle
// while the output is not stalled; a byte that releases several results
// (a bad continuation, or the end of text with bytes still waiting) holds
// the input until the last of them is given. Four-byte sequences, invalid
// bytes and 0x7F give 0xFFFD; last_of_text marks a text's final code point.
module utf8_to_bmp_codepoint_decoder_top
   import u8bmp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_text,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_code_point,
   output logic        rsp_last_of_text
);

   logic [8*WinBytes-1:0] win_ff, win_in, win_shift;
   cnt_type               cnt_ff, cnt_in, base_cnt, shift_cnt;
   logic                  active_ff, active_in;
   logic                  end_ff, end_in;
   logic                  out_valid_ff, out_valid_in;
   logic [15:0]           out_code_ff, out_code_in;
   logic                  out_last_ff, out_last_in;

   logic [7:0]  b0, b1, b2, b3;
   cnt_type     need, consume, rem;
   logic        emit, hold, bad, short_seq;
   logic [15:0] code;
   logic        can_emit, fire_out, step_done, accept;

   assign b0 = win_ff[7:0];
   assign b1 = win_ff[15:8];
   assign b2 = win_ff[23:16];
   assign b3 = win_ff[31:24];

   always_comb begin
      need      = seq_len(b0);
      short_seq = cnt_ff < need;
      bad       = ((cnt_ff > cnt_type'(1)) && (need > cnt_type'(1)) && !is_cont(b1)) ||
                  ((cnt_ff > cnt_type'(2)) && (need > cnt_type'(2)) && !is_cont(b2)) ||
                  ((cnt_ff > cnt_type'(3)) && (need > cnt_type'(3)) && !is_cont(b3));
      emit      = 1'b1;
      hold      = 1'b0;
      consume   = cnt_type'(1);
      code      = BadCode;
      if (b0 < DelByte) begin
         code = {8'h00, b0};
      end else if (need == '0 || bad) begin
         code = BadCode;
      end else if (short_seq) begin
         if (!end_ff) begin
            emit = 1'b0;
            hold = 1'b1;
         end
      end else begin
         consume = need;
         case (need)
            cnt_type'(2): code = {5'b00000, b0[4:0], b1[5:0]};
            cnt_type'(3): code = {b0[3:0], b1[5:0], b2[5:0]};
            default:      code = BadCode;
         endcase
      end
   end

   assign rem       = cnt_ff - consume;
   assign can_emit  = !out_valid_ff || rsp_ready;
   assign fire_out  = active_ff && emit && can_emit;
   assign step_done = active_ff && (hold || (fire_out && rem == '0));
   assign req_ready = !active_ff || step_done;
   assign accept    = req_valid && req_ready;

   always_comb begin
      shift_cnt    = fire_out ? consume : '0;
      base_cnt     = cnt_ff - shift_cnt;
      win_shift    = win_ff >> {shift_cnt, 3'b000};
      win_in       = win_shift;
      cnt_in       = base_cnt;
      end_in       = end_ff;
      active_in    = active_ff && !step_done;
      if (accept) begin
         win_in[{base_cnt[1:0], 3'b000} +: 8] = req_data_byte;
         cnt_in    = base_cnt + cnt_type'(1);
         end_in    = req_end_of_text;
         active_in = 1'b1;
      end
      out_valid_in = out_valid_ff && !rsp_ready;
      out_code_in  = out_code_ff;
      out_last_in  = out_last_ff;
      if (fire_out) begin
         out_valid_in = 1'b1;
         out_code_in  = code;
         out_last_in  = end_ff && (rem == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         active_ff    <= 1'b0;
         end_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         active_ff    <= active_in;
         end_ff       <= end_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff      <= win_in;
      out_code_ff <= out_code_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_code_point   = out_code_ff;
   assign rsp_last_of_text = out_last_ff;

`ifndef SYNTHESIS
   a_idle_fits: assert property (@(posedge clock) disable iff (reset)
      !active_ff |-> cnt_ff <= cnt_type'(3))
      else $error("waiting window holds more than three bytes");

   a_active_nonempty: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (cnt_ff != '0 && cnt_ff <= cnt_type'(WinBytes)))
      else $error("active window empty or overfull");

   a_accept_active: assert property (@(posedge clock) disable iff (reset)
      accept |=> active_ff)
      else $error("accepted byte not under decode");

   a_last_flush: assert property (@(posedge clock) disable iff (reset)
      (fire_out && end_ff && rem == '0) |=>
         ((!active_ff && cnt_ff == '0) || (active_ff && cnt_ff == cnt_type'(1))))
      else $error("bytes left over after end of text");
`endif

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top
   import u8bmp_pkg::*;
();

   typedef struct packed {
      logic [15:0] code_point;
      logic        last_of_text;
   } code_point_type;

   localparam int QuietLimit = 3000;
   localparam int HoldCycles = 300;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_data_byte;
   logic        req_end_of_text;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_code_point;
   logic        rsp_last_of_text;

   code_point_type code_points_due[$];
   logic [7:0]  held_bytes[3];
   int          held_count = 0;

   int          mismatches = 0;
   int          bytes_sent = 0;
   int          quiet_cycles = 0;
   int          burst_left = 0;
   bit          sender_gaps = 1'b0;
   logic        rsp_stalls = 1'b0;
   logic [15:0] stall_pat = 16'hB5A7;
   int          pat_age = 0;
   int          hold_id = 0;
   int          hold_seen = 0;
   int          hold_left = 0;

   utf8_to_bmp_codepoint_decoder_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_end_of_text  (req_end_of_text),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_code_point   (rsp_code_point),
      .rsp_last_of_text (rsp_last_of_text)
   );

   always #1 clock = ~clock;

   function automatic void decode_utf8_byte(input logic [7:0] new_byte, input logic eot);
      logic [7:0]  win[4];
      logic [15:0] cps[4];
      logic [7:0]  b0;
      logic        bad;
      int          n;
      int          pos;
      int          avail;
      int          need;
      int          look;
      int          cnt;
      code_point_type item;
      n = held_count;
      pos = 0;
      cnt = 0;
      for (int i = 0; i < n; i++) win[i] = held_bytes[i];
      win[n] = new_byte;
      n++;
      while (pos < n) begin
         b0 = win[pos];
         avail = n - pos;
         bad = 1'b0;
         if (b0 < DelByte) begin
            cps[cnt] = {8'h00, b0};
            cnt++;
            pos++;
            continue;
         end
         if ((b0 & Lead2Mask) == Lead2Val) need = 2;
         else if ((b0 & Lead3Mask) == Lead3Val) need = 3;
         else if ((b0 & Lead4Mask) == Lead4Val) need = 4;
         else need = 0;
         if (need == 0) begin
            cps[cnt] = BadCode;
            cnt++;
            pos++;
            continue;
         end
         look = (avail < need) ? avail : need;
         for (int i = 1; i < look; i++) begin
            if ((win[pos+i] & ContMask) != ContVal) bad = 1'b1;
         end
         if (!bad && avail < need) begin
            if (!eot) break;
            bad = 1'b1;
         end
         if (bad) begin
            cps[cnt] = BadCode;
            cnt++;
            pos++;
            continue;
         end
         if (need == 2) cps[cnt] = {5'b0, b0[4:0], win[pos+1][5:0]};
         else if (need == 3) cps[cnt] = {b0[3:0], win[pos+1][5:0], win[pos+2][5:0]};
         else cps[cnt] = BadCode;
         cnt++;
         pos += need;
      end
      held_count = n - pos;
      for (int i = 0; i < held_count; i++) held_bytes[i] = win[pos+i];
      for (int k = 0; k < cnt; k++) begin
         item.code_point = cps[k];
         item.last_of_text = eot && (k == cnt - 1);
         code_points_due.push_back(item);
      end
   endfunction

   function automatic logic [7:0] lead_for(input int len);
      if (len == 2) return {3'b110, 5'($urandom)};
      if (len == 3) return {4'b1110, 4'($urandom)};
      return {5'b11110, 3'($urandom)};
   endfunction

   function automatic logic [7:0] cont_byte();
      return {2'b10, 6'($urandom)};
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic eot);
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_end_of_text <= eot;
      decode_utf8_byte(b, eot);
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
      if (sender_gaps) begin
         if (burst_left == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            burst_left = $urandom_range(1, 12);
         end else begin
            burst_left--;
         end
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (code_points_due.size() != 0) @(posedge clock);
   endtask

   task automatic send_random_char(input int eot_odds);
      int         kind;
      int         len;
      int         cut;
      logic       eot;
      logic [7:0] other;
      kind = $urandom_range(0, 9);
      eot = ($urandom_range(0, eot_odds) == 0);
      case (kind)
         0, 1, 2, 3: begin
            send_byte(8'($urandom_range(0, 126)), eot);
         end
         4, 5: begin
            send_byte(lead_for(2), 1'b0);
            send_byte(cont_byte(), eot);
         end
         6, 7: begin
            send_byte(lead_for(3), 1'b0);
            send_byte(cont_byte(), 1'b0);
            send_byte(cont_byte(), eot);
         end
         8: begin
            send_byte(lead_for(4), 1'b0);
            send_byte(cont_byte(), 1'b0);
            send_byte(cont_byte(), 1'b0);
            send_byte(cont_byte(), eot);
         end
         default: begin
            len = $urandom_range(2, 4);
            cut = $urandom_range(0, len - 2);
            if ($urandom_range(0, 1) == 0) begin
               send_byte(lead_for(len), cut == 0);
               for (int i = 1; i <= cut; i++) send_byte(cont_byte(), i == cut);
            end else begin
               send_byte(lead_for(len), 1'b0);
               for (int i = 0; i < cut; i++) send_byte(cont_byte(), 1'b0);
               other = $urandom_range(0, 1) ? {1'b0, 7'($urandom)} : {2'b11, 6'($urandom)};
               send_byte(other, eot);
            end
         end
      endcase
   endtask

   task automatic test_directed();
      sender_gaps = 1'b1;
      rsp_stalls <= 1'b1;
      send_byte(8'h00, 1'b0);
      send_byte(8'h7E, 1'b0);
      send_byte(DelByte, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hF8, 1'b0);
      send_byte(8'hC2, 1'b0);
      send_byte(8'hA9, 1'b0);
      send_byte(8'hDF, 1'b0);
      send_byte(8'hBF, 1'b0);
      send_byte(8'hEF, 1'b0);
      send_byte(8'hBF, 1'b0);
      send_byte(8'hBF, 1'b0);
      send_byte(8'hF0, 1'b0);
      send_byte(8'h9F, 1'b0);
      send_byte(8'h98, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hE2, 1'b0);
      send_byte(8'h41, 1'b0);
      send_byte(8'hE2, 1'b0);
      send_byte(8'h82, 1'b0);
      send_byte(8'h41, 1'b0);
      send_byte(8'hF4, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h80, 1'b1);
      send_byte(8'hC3, 1'b1);
      wait_drained();
   endtask

   task automatic test_well_formed_text();
      int first;
      first = bytes_sent;
      sender_gaps = 1'b1;
      rsp_stalls <= 1'b1;
      while (bytes_sent - first < 80) send_random_char(7);
      wait_drained();
   endtask

   task automatic test_backlog();
      int first;
      first = bytes_sent;
      sender_gaps = 1'b0;
      rsp_stalls <= 1'b0;
      hold_id <= hold_id + 1;
      while (bytes_sent - first < 24) send_random_char(5);
      wait_drained();
   endtask

   task automatic test_noise();
      int first;
      first = bytes_sent;
      sender_gaps = 1'b0;
      rsp_stalls <= 1'b0;
      while (bytes_sent - first < 20) send_byte(8'($urandom), $urandom_range(0, 5) == 0);
      sender_gaps = 1'b1;
      rsp_stalls <= 1'b1;
      while (bytes_sent - first < 40) send_byte(8'($urandom), $urandom_range(0, 5) == 0);
      send_byte(8'($urandom_range(0, 126)), 1'b1);
      wait_drained();
   endtask

   always @(posedge clock) begin
      if (hold_seen != hold_id) begin
         hold_seen <= hold_id;
         hold_left <= HoldCycles;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (!rsp_stalls) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= stall_pat[0];
         pat_age <= (pat_age == 63) ? 0 : pat_age + 1;
         if (pat_age == 63) begin
            stall_pat <= 16'($urandom) | 16'h0001;
         end else begin
            stall_pat <= {stall_pat[0], stall_pat[15:1]};
         end
      end
   end

   always @(posedge clock) begin
      code_point_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         if (code_points_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected code point %h last %b", rsp_code_point, rsp_last_of_text);
            end
         end else begin
            due = code_points_due.pop_front();
            if (rsp_code_point !== due.code_point || rsp_last_of_text !== due.last_of_text) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("code point mismatch: expected %h last %b, got %h last %b",
                           due.code_point, due.last_of_text, rsp_code_point, rsp_last_of_text);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QuietLimit) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data_byte <= 8'h00;
      req_end_of_text <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_well_formed_text();
      test_backlog();
      test_noise();
      wait_drained();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && code_points_due.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
